/* hdl/aimd_pkg.sv */
// shared types and constants for the aimd window controller
package aimd_pkg;

    localparam int CELL_BYTES = 80;

    localparam int CELLS_W  = 32;
    localparam int COUNT_W  = 32;
    localparam int WIN_W    = 16;
    localparam int AVG_W    = 39;
    localparam int MULT_W   = $clog2(CELL_BYTES + 1);
    localparam int BYTES_W  = CELLS_W + MULT_W;
    localparam int STEP_W   = $clog2(BYTES_W + 1);
    localparam int REG_IDX_W = 3;

    localparam logic [AVG_W-1:0]   AVG_MAX = '1;
    localparam logic [WIN_W-1:0]   WIN_MAX = '1;
    localparam logic [MULT_W-1:0]  CELL_BYTES_C = MULT_W'(CELL_BYTES);

    localparam logic [AVG_W-1:0] LOWER_RST   = AVG_W'(75000);
    localparam logic [AVG_W-1:0] UPPER_RST   = AVG_W'(750000);
    localparam logic [WIN_W-1:0] FLOOR_RST   = WIN_W'(118);
    localparam logic [WIN_W-1:0] CEILING_RST = WIN_W'(65535);
    localparam logic [WIN_W-1:0] STEP_RST    = WIN_W'(118);
    localparam logic [WIN_W-1:0] DIVISOR_RST = WIN_W'(2);
    localparam logic [WIN_W-1:0] WINDOW_RST  = WIN_W'(65535);

    // register indexes on the configuration channel
    localparam logic [REG_IDX_W-1:0] REG_LOWER   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_UPPER   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FLOOR   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CEILING = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STEP    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DIVISOR = 3'd5;

    typedef enum logic [1:0] {
        ACT_HOLD = 2'd0,
        ACT_DEC  = 2'd1,
        ACT_INC  = 2'd2
    } action_t;

    typedef struct packed {
        logic [AVG_W-1:0] lower;
        logic [AVG_W-1:0] upper;
        logic [WIN_W-1:0] floor_val;
        logic [WIN_W-1:0] ceiling;
        logic [WIN_W-1:0] step;
        logic [WIN_W-1:0] divisor;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_rsp_t;

endpackage

/* hdl/aimd_if.sv */
// handshake channel interfaces: measurement input, result output, configuration
interface aimd_meas_if;
    logic                          valid;
    logic                          ready;
    logic [aimd_pkg::CELLS_W-1:0]  depth_sum_cells;
    logic [aimd_pkg::COUNT_W-1:0]  packet_total;

    modport source (output valid, depth_sum_cells, packet_total, input ready);
    modport sink (input valid, depth_sum_cells, packet_total, output ready);
endinterface

interface aimd_result_if;
    logic                        valid;
    logic                        ready;
    logic [aimd_pkg::WIN_W-1:0]  window_new;
    logic [aimd_pkg::AVG_W-1:0]  average_depth_bytes;
    logic                        bank_read;
    logic [1:0]                  action;

    modport source (output valid, window_new, average_depth_bytes, bank_read, action,
                    input ready);
    modport sink (input valid, window_new, average_depth_bytes, bank_read, action,
                  output ready);
endinterface

interface aimd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [aimd_pkg::REG_IDX_W-1:0]  index;
    logic [aimd_pkg::AVG_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hdl/aimd_regs.sv */
// configuration register file for thresholds and window limits
module aimd_regs (
    input  logic              clk,
    input  logic              rst_n,
    aimd_cfg_if.sink          cfg,
    output aimd_pkg::cfg_t    regs
);
    import aimd_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.lower     <= LOWER_RST;
            regs_reg.upper     <= UPPER_RST;
            regs_reg.floor_val <= FLOOR_RST;
            regs_reg.ceiling   <= CEILING_RST;
            regs_reg.step      <= STEP_RST;
            regs_reg.divisor   <= DIVISOR_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            // writes to unknown indexes are dropped
            unique case (cfg.index)
                REG_LOWER:   regs_reg.lower     <= cfg.data;
                REG_UPPER:   regs_reg.upper     <= cfg.data;
                REG_FLOOR:   regs_reg.floor_val <= cfg.data[WIN_W-1:0];
                REG_CEILING: regs_reg.ceiling   <= cfg.data[WIN_W-1:0];
                REG_STEP:    regs_reg.step      <= cfg.data[WIN_W-1:0];
                REG_DIVISOR: regs_reg.divisor   <= cfg.data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

/* hdl/aimd_div.sv */
// shared restoring divider, one quotient bit per cycle
module aimd_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  aimd_pkg::div_req_t              req,
    input  logic [aimd_pkg::BYTES_W-1:0]    dividend,
    input  logic [aimd_pkg::COUNT_W-1:0]    divisor,
    output aimd_pkg::div_rsp_t              rsp,
    output logic [aimd_pkg::BYTES_W-1:0]    quotient
);
    import aimd_pkg::*;

    logic [BYTES_W-1:0] quo_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] dvs_reg;
    logic [STEP_W-1:0]  cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [COUNT_W:0]   rem_shift;
    logic [COUNT_W:0]   rem_diff;
    logic               fits;

    // quotient bits enter at the bottom, dividend bits leave at the top
    assign rem_shift = {rem_reg, quo_reg[BYTES_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign fits      = rem_shift >= {1'b0, dvs_reg};

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[BYTES_W-2:0], fits};
            rem_reg <= fits ? rem_diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
        end
    end

    property p_start_idle;
        @(posedge clk) disable iff (!rst_n) req.start |-> !busy_reg;
    endproperty
    a_start_idle: assert property (p_start_idle)
        else $error("divider started while busy");

    property p_done_after_busy;
        @(posedge clk) disable iff (!rst_n) done_reg |-> $past(busy_reg) && !busy_reg;
    endproperty
    a_done_after_busy: assert property (p_done_after_busy)
        else $error("divider done without a running division");

    property p_busy_count;
        @(posedge clk) disable iff (!rst_n) busy_reg |-> cnt_reg != '0;
    endproperty
    a_busy_count: assert property (p_busy_count)
        else $error("divider busy with no steps left");

endmodule

/* hdl/aimd_window_controller.sv */
// aimd window controller top level: sequencer around a shared divider
// One measurement round is taken per transaction on meas. The sequencer scales the
// cell sum by the bytes per cell with one multiply, runs the shared bit-serial divider
// for the average (over the 39 dividend bits at 80 bytes per cell, skipped on a
// zero packet count), then on a decrease runs it again over the 16 window bits.
// An accepted item passes through S_MUL, S_AVG, S_AVG_WAIT (not on a zero packet count),
// S_DECIDE, S_WIN_WAIT (on a decrease only) and S_FINISH, which waits while the previous
// result still sits in the output register. meas is not ready until the result is
// loaded into the output register, which holds it on result until taken.
// Configuration writes are taken every cycle and must only be made while idle.
module aimd_window_controller (
    input  logic       clk,
    input  logic       rst_n,
    aimd_meas_if.sink  meas,
    aimd_result_if.source result,
    aimd_cfg_if.sink   cfg
);
    import aimd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_AVG,
        S_AVG_WAIT,
        S_DECIDE,
        S_WIN_WAIT,
        S_FINISH
    } state_t;

    cfg_t               regs;
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    logic [BYTES_W-1:0] div_dividend;
    logic [COUNT_W-1:0] div_divisor;
    logic [BYTES_W-1:0] div_quotient;

    state_t             state_reg, state_next;
    logic [CELLS_W-1:0] cells_reg, cells_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [AVG_W-1:0]   avg_reg, avg_next;
    logic [WIN_W-1:0]   win_reg, win_next;
    logic               bank_reg, bank_next;
    logic               bank_rd_reg, bank_rd_next;
    action_t            act_reg, act_next;

    logic               out_valid_reg, out_valid_next;
    logic [WIN_W-1:0]   out_win_reg, out_win_next;
    logic [AVG_W-1:0]   out_avg_reg, out_avg_next;
    logic               out_bank_reg, out_bank_next;
    action_t            out_act_reg, out_act_next;

    logic [WIN_W:0]     inc_sum;
    logic [WIN_W-1:0]   inc_sat;
    logic [WIN_W-1:0]   inc_win;
    logic [WIN_W-1:0]   dec_quo;
    logic [WIN_W-1:0]   dec_win;
    logic [WIN_W-1:0]   eff_divisor;
    logic [AVG_W-1:0]   avg_sat;

    aimd_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    aimd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .rsp      (div_rsp),
        .quotient (div_quotient)
    );

    assign meas.ready                 = (state_reg == S_IDLE);
    assign result.valid               = out_valid_reg;
    assign result.window_new          = out_win_reg;
    assign result.average_depth_bytes = out_avg_reg;
    assign result.bank_read           = out_bank_reg;
    assign result.action              = out_act_reg;

    // window update arithmetic
    assign inc_sum     = {1'b0, win_reg} + {1'b0, regs.step};
    assign inc_sat     = inc_sum[WIN_W] ? WIN_MAX : inc_sum[WIN_W-1:0];
    assign inc_win     = (inc_sat < regs.ceiling) ? inc_sat : regs.ceiling;
    assign dec_quo     = div_quotient[WIN_W-1:0];
    assign dec_win     = (dec_quo > regs.floor_val) ? dec_quo : regs.floor_val;
    assign eff_divisor = (regs.divisor == '0) ? WIN_W'(1) : regs.divisor;
    assign avg_sat     = (div_quotient > BYTES_W'(AVG_MAX)) ? AVG_MAX
                                                            : div_quotient[AVG_W-1:0];

    // window is aligned to the top so 16 steps bring out its quotient
    assign div_dividend = (state_reg == S_DECIDE)
                        ? {win_reg, {(BYTES_W-WIN_W){1'b0}}} : bytes_reg;
    assign div_divisor  = (state_reg == S_DECIDE)
                        ? {{(COUNT_W-WIN_W){1'b0}}, eff_divisor} : count_reg;

    always_comb
    begin
        state_next     = state_reg;
        cells_next     = cells_reg;
        count_next     = count_reg;
        bytes_next     = bytes_reg;
        avg_next       = avg_reg;
        win_next       = win_reg;
        bank_next      = bank_reg;
        bank_rd_next   = bank_rd_reg;
        act_next       = act_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_win_next   = out_win_reg;
        out_avg_next   = out_avg_reg;
        out_bank_next  = out_bank_reg;
        out_act_next   = out_act_reg;
        div_req.start  = 1'b0;
        div_req.steps  = STEP_W'(BYTES_W);

        unique case (state_reg)
            S_IDLE:
            begin
                if (meas.valid)
                begin
                    cells_next   = meas.depth_sum_cells;
                    count_next   = meas.packet_total;
                    bank_rd_next = bank_reg;
                    bank_next    = ~bank_reg;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                bytes_next = BYTES_W'(cells_reg) * BYTES_W'(CELL_BYTES_C);
                state_next = S_AVG;
            end
            S_AVG:
            begin
                if (count_reg == '0)
                begin
                    avg_next   = '0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_AVG_WAIT;
                end
            end
            S_AVG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = avg_sat;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                // decrease test comes first and wins
                priority if (avg_reg > regs.upper)
                begin
                    div_req.start = 1'b1;
                    div_req.steps = STEP_W'(WIN_W);
                    act_next      = ACT_DEC;
                    state_next    = S_WIN_WAIT;
                end
                else if (avg_reg < regs.lower)
                begin
                    win_next   = inc_win;
                    act_next   = ACT_INC;
                    state_next = S_FINISH;
                end
                else
                begin
                    act_next   = ACT_HOLD;
                    state_next = S_FINISH;
                end
            end
            S_WIN_WAIT:
            begin
                if (div_rsp.done)
                begin
                    win_next   = dec_win;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_win_next   = win_reg;
                    out_avg_next   = avg_reg;
                    out_bank_next  = bank_rd_reg;
                    out_act_next   = act_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            win_reg       <= WINDOW_RST;
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            bank_reg      <= bank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cells_reg    <= cells_next;
        count_reg    <= count_next;
        bytes_reg    <= bytes_next;
        avg_reg      <= avg_next;
        bank_rd_reg  <= bank_rd_next;
        act_reg      <= act_next;
        out_win_reg  <= out_win_next;
        out_avg_reg  <= out_avg_next;
        out_bank_reg <= out_bank_next;
        out_act_reg  <= out_act_next;
    end

    property p_busy_after_accept;
        @(posedge clk) disable iff (!rst_n) meas.valid && meas.ready |=> !meas.ready;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("input accepted again while a round is in progress");

    property p_inc_capped;
        @(posedge clk) disable iff (!rst_n)
            out_valid_reg && (out_act_reg == ACT_INC) |-> out_win_reg <= regs.ceiling;
    endproperty
    a_inc_capped: assert property (p_inc_capped)
        else $error("increased window above ceiling");

    property p_dec_floored;
        @(posedge clk) disable iff (!rst_n)
            out_valid_reg && (out_act_reg == ACT_DEC) |-> out_win_reg >= regs.floor_val;
    endproperty
    a_dec_floored: assert property (p_dec_floored)
        else $error("decreased window below floor");

    property p_div_only_when_waiting;
        @(posedge clk) disable iff (!rst_n)
            div_rsp.busy |-> (state_reg == S_AVG_WAIT) || (state_reg == S_WIN_WAIT);
    endproperty
    a_div_only_when_waiting: assert property (p_div_only_when_waiting)
        else $error("divider running outside a wait state");

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for the aimd window controller: directed table, random rounds
module tb_top;
    import aimd_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_CYCLES  = 400;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ROUNDS  = 110;
    localparam int MAX_GAP       = 13;

    // indexes past the last register, writes there must be dropped
    localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [WIN_W-1:0] window;
        logic [AVG_W-1:0] avg;
        logic             bank;
        action_t          act;
    } round_result_t;

    typedef enum logic {
        ROW_ROUND,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CELLS_W-1:0]   cells;
        logic [COUNT_W-1:0]   count;
        logic [REG_IDX_W-1:0] index;
        logic [AVG_W-1:0]     data;
        logic                 typed;
        round_result_t        result;
    } stim_row_t;

    logic clk;
    logic rst_n;

    aimd_meas_if   meas_ch();
    aimd_result_if res_ch();
    aimd_cfg_if    cfg_ch();

    aimd_window_controller dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .meas   (meas_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // shadow of the block's registers and state
    cfg_t             live_cfg;
    logic [WIN_W-1:0] cur_window;
    logic             cur_bank;

    round_result_t pending_rounds[$];
    stim_row_t     stim_table[$];

    int  mismatches    = 0;
    int  rounds_seen   = 0;
    int  holds_seen    = 0;
    int  decs_seen     = 0;
    int  incs_seen     = 0;
    int  writes_done   = 0;
    int  cycles        = 0;
    bit  send_idle_on  = 1'b1;
    bit  recv_idle_on  = 1'b1;
    bit  stall_req     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic round_result_t aimd_round(input logic [CELLS_W-1:0] cells,
                                                 input logic [COUNT_W-1:0] count);
        logic [63:0]      scaled;
        logic [63:0]      avg;
        logic [WIN_W-1:0] div;
        logic [WIN_W-1:0] quot;
        logic [WIN_W:0]   sum;
        round_result_t    r;
        scaled = 64'(cells) * 64'(CELL_BYTES);
        avg = (count == '0) ? 64'd0 : scaled / 64'(count);
        if (avg > 64'(AVG_MAX))
            avg = 64'(AVG_MAX);
        r.avg  = avg[AVG_W-1:0];
        r.bank = cur_bank;
        cur_bank = ~cur_bank;
        // decrease is tested first, so it wins when both thresholds are crossed
        if (r.avg > live_cfg.upper)
        begin
            div = (live_cfg.divisor == '0) ? WIN_W'(1) : live_cfg.divisor;
            quot = cur_window / div;
            cur_window = (quot > live_cfg.floor_val) ? quot : live_cfg.floor_val;
            r.act = ACT_DEC;
        end
        else if (r.avg < live_cfg.lower)
        begin
            sum = (WIN_W+1)'(cur_window) + (WIN_W+1)'(live_cfg.step);
            if (sum > (WIN_W+1)'(WIN_MAX))
                sum = (WIN_W+1)'(WIN_MAX);
            cur_window = (sum[WIN_W-1:0] < live_cfg.ceiling) ? sum[WIN_W-1:0]
                                                               : live_cfg.ceiling;
            r.act = ACT_INC;
        end
        else
        begin
            r.act = ACT_HOLD;
        end
        r.window = cur_window;
        return r;
    endfunction

    function automatic void apply_write(input logic [REG_IDX_W-1:0] index,
                                        input logic [AVG_W-1:0] data);
        case (index)
            REG_LOWER:   live_cfg.lower     = data;
            REG_UPPER:   live_cfg.upper     = data;
            REG_FLOOR:   live_cfg.floor_val = data[WIN_W-1:0];
            REG_CEILING: live_cfg.ceiling   = data[WIN_W-1:0];
            REG_STEP:    live_cfg.step      = data[WIN_W-1:0];
            REG_DIVISOR: live_cfg.divisor   = data[WIN_W-1:0];
            default:     ;
        endcase
    endfunction

    function automatic round_result_t make_result(input logic [WIN_W-1:0] window,
                                                  input logic [AVG_W-1:0] avg,
                                                  input logic bank, input action_t act);
        round_result_t r;
        r.window = window;
        r.avg    = avg;
        r.bank   = bank;
        r.act    = act;
        return r;
    endfunction

    function automatic stim_row_t round_row(input logic [CELLS_W-1:0] cells,
                                            input logic [COUNT_W-1:0] count);
        stim_row_t row;
        row.kind   = ROW_ROUND;
        row.cells  = cells;
        row.count  = count;
        row.index  = '0;
        row.data   = '0;
        row.typed  = 1'b0;
        row.result = '0;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic [CELLS_W-1:0] cells,
                                            input logic [COUNT_W-1:0] count,
                                            input round_result_t result);
        stim_row_t row;
        row = round_row(cells, count);
        row.typed  = 1'b1;
        row.result = result;
        return row;
    endfunction

    function automatic stim_row_t write_row(input logic [REG_IDX_W-1:0] index,
                                            input logic [AVG_W-1:0] data);
        stim_row_t row;
        row = round_row('0, '0);
        row.kind  = ROW_WRITE;
        row.index = index;
        row.data  = data;
        return row;
    endfunction

    // log-uniform magnitude so small and huge values both show up
    function automatic logic [AVG_W-1:0] rand_magnitude();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return AVG_W'(r >> $urandom_range(25, 63));
    endfunction

    function automatic logic [AVG_W-1:0] rand_threshold();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return AVG_MAX;
            2:       return LOWER_RST;
            3:       return UPPER_RST;
            default: return rand_magnitude();
        endcase
    endfunction

    function automatic logic [WIN_W-1:0] rand_window_value();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return WIN_MAX;
            2:       return WIN_W'($urandom_range(0, 500));
            default: return WIN_W'($urandom());
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    task automatic send_round(input logic [CELLS_W-1:0] cells,
                              input logic [COUNT_W-1:0] count,
                              input logic typed, input round_result_t result);
        int            gap;
        round_result_t pred;
        gap = send_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            meas_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        meas_ch.valid           <= 1'b1;
        meas_ch.depth_sum_cells <= cells;
        meas_ch.packet_total    <= count;
        do
            @(posedge clk);
        while (!meas_ch.ready);
        pred = aimd_round(cells, count);
        pending_rounds.push_back(typed ? result : pred);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] index,
                             input logic [AVG_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        apply_write(index, data);
        writes_done++;
    endtask

    // stop offering rounds and let the block run dry
    task automatic settle_idle();
        meas_ch.valid <= 1'b0;
        while (pending_rounds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : result_sink
        int            gap;
        round_result_t got;
        round_result_t want;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (stall_req)
            begin
                gap = STALL_CYCLES;
                stall_req = 1'b0;
            end
            else
            begin
                gap = recv_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            got.window = res_ch.window_new;
            got.avg    = res_ch.average_depth_bytes;
            got.bank   = res_ch.bank_read;
            got.act    = action_t'(res_ch.action);
            rounds_seen++;
            case (got.act)
                ACT_HOLD: holds_seen++;
                ACT_DEC:  decs_seen++;
                ACT_INC:  incs_seen++;
                default:  ;
            endcase
            if (pending_rounds.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result: window %0d avg %0d bank %0d act %0d",
                                        got.window, got.avg, got.bank, got.act));
            end
            else
            begin
                want = pending_rounds.pop_front();
                if (got !== want)
                    flag_mismatch($sformatf({"round %0d: window exp %0d got %0d, avg exp %0d ",
                                             "got %0d, bank exp %0d got %0d, act exp %0d got %0d"},
                                            rounds_seen, want.window, got.window, want.avg,
                                            got.avg, want.bank, got.bank, want.act, got.act));
            end
        end
    end

    initial
    begin : stimulus
        logic [CELLS_W-1:0] cells;
        logic [COUNT_W-1:0] count;
        logic [AVG_W-1:0]   thr;
        logic [AVG_W-1:0]   lower;
        logic [AVG_W:0]     upper_sum;
        bit                 in_rounds;

        meas_ch.valid           <= 1'b0;
        meas_ch.depth_sum_cells <= '0;
        meas_ch.packet_total    <= '0;
        res_ch.ready            <= 1'b0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.index            <= '0;
        cfg_ch.data             <= '0;
        rst_n                   <= 1'b0;

        live_cfg.lower     = LOWER_RST;
        live_cfg.upper     = UPPER_RST;
        live_cfg.floor_val = FLOOR_RST;
        live_cfg.ceiling   = CEILING_RST;
        live_cfg.step      = STEP_RST;
        live_cfg.divisor   = DIVISOR_RST;
        cur_window = WINDOW_RST;
        cur_bank   = 1'b0;

        // reset settings: zero count, full-scale average, tiny average
        stim_table.push_back(typed_row(32'd0, 32'd0,
                                       make_result(16'd65535, '0, 1'b0, ACT_INC)));
        stim_table.push_back(typed_row(32'hFFFF_FFFF, 32'd1,
                                       make_result(16'd32767, 39'd343597383600, 1'b1, ACT_DEC)));
        stim_table.push_back(typed_row(32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       make_result(16'd32885, 39'd80, 1'b0, ACT_INC)));
        // right at and just past the upper threshold, just either side of the lower one
        stim_table.push_back(round_row(32'd9375, 32'd1));
        stim_table.push_back(round_row(32'd9376, 32'd1));
        stim_table.push_back(round_row(32'd937, 32'd1));
        stim_table.push_back(round_row(32'd938, 32'd1));
        stim_table.push_back(round_row(32'd1, 32'd0));
        stim_table.push_back(round_row(32'd0, 32'd1));
        // zero divisor leaves the window as is
        stim_table.push_back(write_row(REG_DIVISOR, '0));
        stim_table.push_back(round_row(32'hFFFF_FFFF, 32'd1));
        // floor above the window pulls a decrease upward
        stim_table.push_back(write_row(REG_FLOOR, 39'(WIN_MAX)));
        stim_table.push_back(round_row(32'hFFFF_FFFF, 32'd1));
        stim_table.push_back(write_row(REG_FLOOR, '0));
        stim_table.push_back(write_row(REG_DIVISOR, 39'(WIN_MAX)));
        stim_table.push_back(round_row(32'hFFFF_FFFF, 32'd1));
        stim_table.push_back(round_row(32'hFFFF_FFFF, 32'd1));
        // step saturation, then a ceiling below the window
        stim_table.push_back(write_row(REG_STEP, 39'(WIN_MAX)));
        stim_table.push_back(round_row(32'd0, 32'd0));
        stim_table.push_back(write_row(REG_CEILING, '0));
        stim_table.push_back(round_row(32'd0, 32'd0));
        stim_table.push_back(write_row(REG_CEILING, 39'd1000));
        stim_table.push_back(write_row(REG_STEP, '0));
        stim_table.push_back(round_row(32'd0, 32'd0));
        // both thresholds crossed at once
        stim_table.push_back(write_row(REG_LOWER, AVG_MAX));
        stim_table.push_back(write_row(REG_UPPER, '0));
        stim_table.push_back(round_row(32'd1, 32'd80));
        stim_table.push_back(round_row(32'd0, 32'd5));
        // neither threshold reachable
        stim_table.push_back(write_row(REG_UPPER, AVG_MAX));
        stim_table.push_back(write_row(REG_LOWER, '0));
        stim_table.push_back(round_row(32'hFFFF_FFFF, 32'd1));
        stim_table.push_back(round_row(32'd0, 32'd0));
        // writes past the register file change nothing
        stim_table.push_back(write_row(REG_SPARE_A, AVG_MAX));
        stim_table.push_back(write_row(REG_SPARE_B, '0));
        stim_table.push_back(round_row(32'd1, 32'd1));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        in_rounds = 1'b0;
        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_WRITE)
            begin
                if (in_rounds)
                    settle_idle();
                write_reg(stim_table[i].index, stim_table[i].data);
                in_rounds = 1'b0;
            end
            else
            begin
                if (!in_rounds)
                    cfg_ch.valid <= 1'b0;
                send_round(stim_table[i].cells, stim_table[i].count,
                           stim_table[i].typed, stim_table[i].result);
                in_rounds = 1'b1;
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle_idle();
            lower = rand_threshold();
            write_reg(REG_LOWER, lower);
            if ($urandom_range(0, 9) < 7)
            begin
                upper_sum = (AVG_W+1)'(lower) + (AVG_W+1)'(rand_magnitude());
                write_reg(REG_UPPER, (upper_sum > (AVG_W+1)'(AVG_MAX)) ? AVG_MAX
                                                                      : upper_sum[AVG_W-1:0]);
            end
            else
            begin
                write_reg(REG_UPPER, rand_threshold());
            end
            // junk in the upper data bits of the narrow registers
            write_reg(REG_FLOOR,   {23'($urandom()), rand_window_value()});
            write_reg(REG_CEILING, {23'($urandom()), rand_window_value()});
            write_reg(REG_STEP,    {23'($urandom()), rand_window_value()});
            write_reg(REG_DIVISOR, {23'($urandom()), rand_window_value()});
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          AVG_W'({$urandom(), $urandom()}));
            cfg_ch.valid <= 1'b0;

            send_idle_on = (phase == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
            recv_idle_on = (phase == 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (phase == 1)
                stall_req = 1'b1;

            for (int n = 0; n < PHASE_ROUNDS; n++)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        cells = $urandom();
                        count = '0;
                    end
                    1, 2:
                    begin
                        cells = $urandom();
                        count = $urandom();
                    end
                    3, 4, 5, 6:
                    begin
                        cells = $urandom() >> $urandom_range(0, 31);
                        count = $urandom() >> $urandom_range(0, 31);
                    end
                    default:
                    begin
                        // land on either side of a threshold
                        thr = $urandom_range(0, 1) ? live_cfg.lower : live_cfg.upper;
                        cells = CELLS_W'(thr / CELL_BYTES) + CELLS_W'($urandom_range(0, 2))
                                - CELLS_W'(1);
                        count = COUNT_W'(1);
                    end
                endcase
                send_round(cells, count, 1'b0, '0);
            end
        end

        settle_idle();
        $display("%0d rounds checked under %0d register writes: %0d holds, %0d decreases, %0d increases",
                 rounds_seen, writes_done, holds_seen, decs_seen, incs_seen);
        $display("included threshold edges, divisor and bound extremes and one %0d-cycle output stall",
                 STALL_CYCLES);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
hdl/aimd_pkg.sv
hdl/aimd_if.sv
hdl/aimd_regs.sv
hdl/aimd_div.sv
hdl/aimd_window_controller.sv
tb/sv/tb_top.sv
